[sv/stps_pkg.sv]
// Shared types and constants of the servo throttle position shaper.
package stps_pkg;

  localparam int unsigned POT_W   = 10;
  localparam int unsigned PITCH_W = 12;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CFG_IW  = 4;
  localparam int unsigned CFG_DW  = 10;

  localparam logic [CFG_IW-1:0] REG_CAL_MIN      = 4'd0;
  localparam logic [CFG_IW-1:0] REG_CAL_MAX      = 4'd1;
  localparam logic [CFG_IW-1:0] REG_REVERSE      = 4'd2;
  localparam logic [CFG_IW-1:0] REG_LIMIT_POS    = 4'd3;
  localparam logic [CFG_IW-1:0] REG_THROTTLE_POS = 4'd4;
  localparam logic [CFG_IW-1:0] REG_GYRO_HORIZ   = 4'd5;
  localparam logic [CFG_IW-1:0] REG_GYRO_THR     = 4'd6;
  localparam logic [CFG_IW-1:0] REG_SHORT_EN     = 4'd7;

  localparam logic [POT_W-1:0] RST_CAL_MIN      = 10'd538;
  localparam logic [POT_W-1:0] RST_CAL_MAX      = 10'd1023;
  localparam logic [POS_W-1:0] RST_LIMIT_POS    = 8'd10;
  localparam logic [POS_W-1:0] RST_THROTTLE_POS = 8'd20;
  localparam logic [POS_W-1:0] RST_GYRO_HORIZ   = 8'd10;
  localparam logic [POS_W-1:0] RST_GYRO_THR     = 8'd20;
  localparam logic [POS_W-1:0] RST_SLEW_POS     = 8'd90;

  localparam logic [POS_W-1:0] POS_LOW    = 8'd25;
  localparam logic [POS_W-1:0] POS_HIGH   = 8'd180;
  localparam logic [POS_W-1:0] SHORT_HIGH = 8'd178;
  localparam logic [POS_W-1:0] SHORT_LOW  = 8'd26;
  localparam int unsigned      POS_SPAN   = 155;
  localparam int unsigned      PITCH_SPAN = 900;

  typedef struct packed {
    logic [POT_W-1:0]   pot_sample;
    logic [PITCH_W-1:0] pitch_angle;
    logic               gyro_inverted;
    logic               gyro_active;
    logic               move_enable;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] target_position;
    logic [POS_W-1:0] servo_position;
    logic             line_circuit;
    logic             throttle_clamped;
    logic             throttle_hold;
  } out_item_t;

endpackage

[sv/stps_if.sv]
// Handshake channel interfaces for input items, result items and register writes.
interface stps_in_if;
  logic                valid;
  logic                ready;
  stps_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stps_out_if;
  logic                valid;
  logic                ready;
  stps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [stps_pkg::CFG_IW-1:0]   index;
  logic [stps_pkg::CFG_DW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/servo_throttle_position_shaper_unit.sv]
// Throttle servo shaper: calibration map, clamps, gyro remap and slew step.
// One shared multiplier and a two-bit-per-cycle restoring divider do the two linear maps.
// An accepted item runs the load, divide, fix, clamp and slew states before result valid;
// the gyro remap adds a divide and fix, an equal calibration range skips the first pair.
// One item at a time: the next item can be accepted in the cycle after the result is taken.
// Reset (rst_ni low, asynchronous) loads register defaults, slew position 90, hold clear.
module servo_throttle_position_shaper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  stps_in_if.sink     in_i,
  stps_out_if.source  out_o,
  stps_cfg_if.sink    cfg_i
);

  localparam int unsigned DIV_W   = 20;
  localparam int unsigned DEN_W   = 10;
  localparam int unsigned DIV_SPC = 2;
  localparam int unsigned DIV_CYC = DIV_W / DIV_SPC;
  localparam int unsigned CNT_W   = $clog2(DIV_CYC);
  localparam int unsigned SUM_W   = DIV_W + 2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_FIX   = 8'b0000_1000,
    S_CLAMP = 8'b0001_0000,
    S_SLEW  = 8'b0010_0000,
    S_OUT   = 8'b0100_0000
  } state_e;

  state_e state_q, state_d;

  logic [stps_pkg::POT_W-1:0] cal_min_q, cal_max_q;
  logic                       reverse_q, short_en_q;
  logic [stps_pkg::POS_W-1:0] lim_q, thr_q, gh_q, gt_q;

  stps_pkg::in_item_t  item_q;
  stps_pkg::out_item_t out_q;
  logic [stps_pkg::POS_W-1:0] slew_q, val_q;
  logic hold_q, line_q, clamped_q, phase_q, neg_q;
  logic [DIV_W-1:0]  num_q, num_n;
  logic [DEN_W-1:0]  den_q, rem_q, rem_n;
  logic [7:0]        off_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [stps_pkg::POS_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > 255) begin
      return 8'd255;
    end else begin
      return v[stps_pkg::POS_W-1:0];
    end
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = out_q;

  // Shared multiplier operands.
  logic               sel_gyro, pneg;
  logic signed [12:0] mul_x, pitch_s, cal_x, cal_d;
  logic signed [9:0]  mul_c, end_gh, gh_gt;
  logic signed [22:0] prod;
  logic [22:0]        prod_abs;
  logic [12:0]        cal_d_abs;
  logic [DEN_W-1:0]   mul_den;
  logic               den_neg;
  logic [7:0]         mul_off;
  logic [stps_pkg::POS_W-1:0] end_pos;

  always_comb begin
    sel_gyro  = (state_q == S_CLAMP);
    pitch_s   = $signed({item_q.pitch_angle[stps_pkg::PITCH_W-1], item_q.pitch_angle});
    pneg      = item_q.pitch_angle[stps_pkg::PITCH_W-1];
    end_pos   = reverse_q ? stps_pkg::POS_LOW : stps_pkg::POS_HIGH;
    end_gh    = $signed({2'b00, end_pos}) - $signed({2'b00, gh_q});
    gh_gt     = $signed({2'b00, gh_q}) - $signed({2'b00, gt_q});
    cal_x     = $signed({3'b000, item_q.pot_sample}) - $signed({3'b000, cal_min_q});
    cal_d     = $signed({3'b000, cal_max_q}) - $signed({3'b000, cal_min_q});
    cal_d_abs = cal_d[12] ? 13'(-cal_d) : 13'(cal_d);
    if (sel_gyro) begin
      if (pneg) begin
        mul_x   = item_q.gyro_inverted ? pitch_s : 13'(pitch_s + 13'sd900);
        mul_c   = end_gh;
        mul_off = gh_q;
      end else begin
        mul_x   = item_q.gyro_inverted ? 13'(pitch_s - 13'sd900) : pitch_s;
        mul_c   = gh_gt;
        mul_off = gt_q;
      end
      mul_den = DEN_W'(stps_pkg::PITCH_SPAN);
      den_neg = item_q.gyro_inverted;
    end else begin
      mul_x   = cal_x;
      mul_c   = reverse_q ? -10'(stps_pkg::POS_SPAN) : 10'(stps_pkg::POS_SPAN);
      mul_off = reverse_q ? stps_pkg::POS_HIGH : stps_pkg::POS_LOW;
      mul_den = cal_d_abs[DEN_W-1:0];
      den_neg = cal_d[12];
    end
    prod     = 23'(mul_x) * 23'(mul_c);
    prod_abs = prod[22] ? 23'(-prod) : 23'(prod);
  end

  // Two restoring division steps per cycle.
  logic [DEN_W:0] trial;
  always_comb begin
    rem_n = rem_q;
    num_n = num_q;
    trial = '0;
    for (int i = 0; i < DIV_SPC; i++) begin
      trial = {rem_n, num_n[DIV_W-1]};
      num_n = {num_n[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_n    = DEN_W'(trial - {1'b0, den_q});
        num_n[0] = 1'b1;
      end else begin
        rem_n = trial[DEN_W-1:0];
      end
    end
  end

  // Quotient with sign and offset, plus the gyro bound.
  logic signed [SUM_W-1:0] quo_s, sum_s, gyro_s;
  always_comb begin
    quo_s  = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
    sum_s  = quo_s + $signed({{(SUM_W-8){1'b0}}, off_q});
    gyro_s = sum_s;
    if (!reverse_q && sum_s < $signed({{(SUM_W-8){1'b0}}, gt_q})) begin
      gyro_s = $signed({{(SUM_W-8){1'b0}}, gt_q});
    end else if (reverse_q && sum_s > $signed({{(SUM_W-8){1'b0}}, gt_q})) begin
      gyro_s = $signed({{(SUM_W-8){1'b0}}, gt_q});
    end
  end

  // Safety, throttle and gyro decisions on the mapped value.
  logic line_c, clamp_c, gh_c, remap_c;
  always_comb begin
    if (!reverse_q) begin
      line_c  = (val_q > stps_pkg::SHORT_HIGH && short_en_q && !item_q.gyro_active) ||
                (val_q < lim_q);
      clamp_c = val_q < thr_q;
      gh_c    = val_q > gh_q;
    end else begin
      line_c  = (val_q < stps_pkg::SHORT_LOW && short_en_q && !item_q.gyro_active) ||
                (val_q > lim_q);
      clamp_c = val_q > thr_q;
      gh_c    = val_q < gh_q;
    end
    remap_c = !line_c && !clamp_c && gh_c && item_q.gyro_active;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_LOAD;
      S_LOAD:  state_d = (cal_min_q == cal_max_q) ? S_CLAMP : S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(DIV_CYC - 1)) state_d = S_FIX;
      S_FIX:   state_d = phase_q ? S_SLEW : S_CLAMP;
      S_CLAMP: state_d = remap_c ? S_DIV : S_SLEW;
      S_SLEW:  state_d = S_OUT;
      S_OUT:   if (out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cal_min_q  <= stps_pkg::RST_CAL_MIN;
      cal_max_q  <= stps_pkg::RST_CAL_MAX;
      reverse_q  <= 1'b0;
      lim_q      <= stps_pkg::RST_LIMIT_POS;
      thr_q      <= stps_pkg::RST_THROTTLE_POS;
      gh_q       <= stps_pkg::RST_GYRO_HORIZ;
      gt_q       <= stps_pkg::RST_GYRO_THR;
      short_en_q <= 1'b0;
      slew_q     <= stps_pkg::RST_SLEW_POS;
      hold_q     <= 1'b0;
      cnt_q      <= '0;
      phase_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          stps_pkg::REG_CAL_MIN:      cal_min_q  <= cfg_i.data;
          stps_pkg::REG_CAL_MAX:      cal_max_q  <= cfg_i.data;
          stps_pkg::REG_REVERSE:      reverse_q  <= cfg_i.data[0];
          stps_pkg::REG_LIMIT_POS:    lim_q      <= cfg_i.data[stps_pkg::POS_W-1:0];
          stps_pkg::REG_THROTTLE_POS: thr_q      <= cfg_i.data[stps_pkg::POS_W-1:0];
          stps_pkg::REG_GYRO_HORIZ:   gh_q       <= cfg_i.data[stps_pkg::POS_W-1:0];
          stps_pkg::REG_GYRO_THR:     gt_q       <= cfg_i.data[stps_pkg::POS_W-1:0];
          stps_pkg::REG_SHORT_EN:     short_en_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      case (state_q)
        S_LOAD: begin
          phase_q <= 1'b0;
          cnt_q   <= '0;
        end
        S_DIV:   cnt_q <= CNT_W'(cnt_q + 1'b1);
        S_CLAMP: begin
          cnt_q   <= '0;
          phase_q <= 1'b1;
          if (!line_c) begin
            if (clamp_c) begin
              hold_q <= 1'b1;
            end else if (gh_c) begin
              hold_q <= 1'b0;
            end
          end
        end
        S_SLEW: begin
          if (item_q.move_enable) begin
            if (slew_q < val_q) begin
              slew_q <= slew_q + 1'b1;
            end else if (slew_q > val_q) begin
              slew_q <= slew_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic [stps_pkg::POS_W-1:0] slew_next;
  always_comb begin
    slew_next = slew_q;
    if (item_q.move_enable) begin
      if (slew_q < val_q) begin
        slew_next = slew_q + 1'b1;
      end else if (slew_q > val_q) begin
        slew_next = slew_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      item_q <= in_i.data;
    end
    if ((state_q == S_LOAD) || (state_q == S_CLAMP && remap_c)) begin
      num_q <= prod_abs[DIV_W-1:0];
      den_q <= mul_den;
      rem_q <= '0;
      neg_q <= prod[22] ^ den_neg;
      off_q <= mul_off;
    end else if (state_q == S_DIV) begin
      num_q <= num_n;
      rem_q <= rem_n;
    end
    case (state_q)
      S_LOAD: val_q <= stps_pkg::POS_LOW;
      S_FIX:  val_q <= phase_q ? sat8(gyro_s) : sat8(sum_s);
      S_CLAMP: begin
        line_q    <= line_c;
        clamped_q <= !line_c && clamp_c;
        if (line_c) begin
          val_q <= lim_q;
        end else if (clamp_c) begin
          val_q <= thr_q;
        end
      end
      S_SLEW: begin
        out_q.target_position  <= val_q;
        out_q.servo_position   <= slew_next;
        out_q.line_circuit     <= line_q;
        out_q.throttle_clamped <= clamped_q;
        out_q.throttle_hold    <= hold_q;
      end
      default: ;
    endcase
  end

endmodule
